@@ rtl/core/modular_square_root_unit_assert.svh @@
// Assertion macros for the modular square root unit
`ifndef MODULAR_SQUARE_ROOT_UNIT_ASSERT_SVH
`define MODULAR_SQUARE_ROOT_UNIT_ASSERT_SVH
`ifndef SYNTH
`define MSR_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define MSR_ASSERT_NEXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define MSR_ASSERT(label, clk, rstn, prop)
`define MSR_ASSERT_NEXT(label, clk, rstn, pre, post)
`endif
`endif

@@ rtl/core/msr_pkg.sv @@
`timescale 1ns / 1ps
package msr_pkg;
  typedef enum logic [1:0] {
    REG_MODULUS     = 2'd0,
    REG_NON_RESIDUE = 2'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    MUL_IDLE = 2'd0,
    MUL_RUN  = 2'd1,
    MUL_DONE = 2'd2
  } mul_state_e;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_RED,
    ST_INV_DIV,
    ST_INV_MUL,
    ST_INV_UPD,
    ST_INV_END,
    ST_SPLIT,
    ST_PA_TEST,
    ST_PA_MUL,
    ST_PA_SQ,
    ST_NR_RED,
    ST_PN_TEST,
    ST_PN_MUL,
    ST_PN_SQ,
    ST_LOOP,
    ST_B,
    ST_C1,
    ST_C2,
    ST_D_TEST,
    ST_D_SQ,
    ST_CMP,
    ST_E_TEST,
    ST_E_SQ,
    ST_N2,
    ST_ROOT,
    ST_OUT
  } seq_state_e;
endpackage

@@ rtl/core/modular_square_root_unit.sv @@
`timescale 1ns / 1ps
// Run time is data dependent, set by the bit-serial modular multiplier and the
// restoring divider that the steps share.
// Throughput: one item at a time; busy is high from start until done_o.
// Results show for one cycle with done_o; the receiver cannot stall.
// Reset: asynchronous active low, modulus 3, non-residue 2, sequencer idle.
`include "modular_square_root_unit_assert.svh"
module modular_square_root_unit #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [WIDTH-1:0] cfg_data_i,
  input  logic             start,
  input  logic [WIDTH-1:0] square_value_i,
  output logic             busy,
  output logic             done_o,
  output logic [WIDTH-1:0] root_o,
  output logic [WIDTH-1:0] other_root_o,
  output logic             no_inverse_o
);
  localparam int unsigned KW = $clog2(WIDTH + 1);

  msr_pkg::seq_state_e st_q, st_d;
  logic [WIDTH-1:0] mod_q, nr_q;
  logic [WIDTH-1:0] a_q, a_d, h_q, h_d, e_q, e_d, acc_q, acc_d, base_q, base_d;
  logic [WIDTH-1:0] a1_q, a1_d, n1_q, n1_d, a2_q, a2_d, n2_q, n2_d, b_q, b_d;
  logic [WIDTH-1:0] r0_q, r0_d, r1_q, r1_d, s0_q, s0_d, s1_q, s1_d, q_q, q_d;
  logic [KW-1:0]    k_q, k_d, i_q, i_d, t_q, t_d;
  logic             corr_q, corr_d, noinv_q, noinv_d;
  logic [WIDTH-1:0] res_q, res_d;

  logic             mul_start, mul_done, div_start, div_done;
  logic [WIDTH-1:0] mx, my, mp, dq, dr, red_num, red_den;

  msr_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .x_i(mx), .y_i(my), .m_i(mod_q),
    .done_o(mul_done), .p_o(mp)
  );

  msr_divider #(.WIDTH(WIDTH)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(red_num), .den_i(red_den),
    .done_o(div_done), .quo_o(dq), .rem_o(dr)
  );

  assign red_num = (st_q == msr_pkg::ST_IDLE)    ? square_value_i :
                   (st_q == msr_pkg::ST_PA_TEST) ? nr_q : r0_q;
  assign red_den = (st_q inside {msr_pkg::ST_IDLE, msr_pkg::ST_RED,
                                 msr_pkg::ST_PA_TEST, msr_pkg::ST_NR_RED}) ? mod_q : r1_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      msr_pkg::ST_IDLE: begin
        if (start) st_d = (mod_q < WIDTH'(2)) ? msr_pkg::ST_OUT : msr_pkg::ST_RED;
      end
      msr_pkg::ST_RED:     if (div_done) st_d = msr_pkg::ST_INV_END;
      msr_pkg::ST_INV_DIV: if (div_done) st_d = msr_pkg::ST_INV_MUL;
      msr_pkg::ST_INV_MUL: if (mul_done) st_d = msr_pkg::ST_INV_UPD;
      msr_pkg::ST_INV_UPD: st_d = msr_pkg::ST_INV_END;
      msr_pkg::ST_INV_END: begin
        if (r1_q != '0) st_d = msr_pkg::ST_INV_DIV;
        else if (r0_q != WIDTH'(1)) st_d = msr_pkg::ST_OUT;
        else st_d = msr_pkg::ST_SPLIT;
      end
      msr_pkg::ST_SPLIT: if (h_q == '0 || h_q[0]) st_d = msr_pkg::ST_PA_TEST;
      msr_pkg::ST_PA_TEST: begin
        if (e_q == '0) st_d = msr_pkg::ST_NR_RED;
        else if (e_q[0]) st_d = msr_pkg::ST_PA_MUL;
        else st_d = msr_pkg::ST_PA_SQ;
      end
      msr_pkg::ST_PA_MUL: if (mul_done) st_d = msr_pkg::ST_PA_SQ;
      msr_pkg::ST_PA_SQ:  if (mul_done) st_d = msr_pkg::ST_PA_TEST;
      msr_pkg::ST_NR_RED: if (div_done) st_d = msr_pkg::ST_PN_TEST;
      msr_pkg::ST_PN_TEST: begin
        if (e_q == '0) st_d = msr_pkg::ST_LOOP;
        else if (e_q[0]) st_d = msr_pkg::ST_PN_MUL;
        else st_d = msr_pkg::ST_PN_SQ;
      end
      msr_pkg::ST_PN_MUL: if (mul_done) st_d = msr_pkg::ST_PN_SQ;
      msr_pkg::ST_PN_SQ:  if (mul_done) st_d = msr_pkg::ST_PN_TEST;
      msr_pkg::ST_LOOP: st_d = ({1'b0, i_q} + (KW+1)'(2) <= {1'b0, k_q}) ? msr_pkg::ST_B
                                                                          : msr_pkg::ST_ROOT;
      msr_pkg::ST_B:  if (mul_done) st_d = msr_pkg::ST_C1;
      msr_pkg::ST_C1: if (mul_done) st_d = msr_pkg::ST_C2;
      msr_pkg::ST_C2: if (mul_done) st_d = msr_pkg::ST_D_TEST;
      msr_pkg::ST_D_TEST: st_d = (t_q == '0) ? msr_pkg::ST_CMP : msr_pkg::ST_D_SQ;
      msr_pkg::ST_D_SQ:   if (mul_done) st_d = msr_pkg::ST_D_TEST;
      msr_pkg::ST_CMP: st_d = corr_d ? msr_pkg::ST_E_TEST : msr_pkg::ST_LOOP;
      msr_pkg::ST_E_TEST: st_d = (t_q == '0) ? msr_pkg::ST_N2 : msr_pkg::ST_E_SQ;
      msr_pkg::ST_E_SQ:   if (mul_done) st_d = msr_pkg::ST_E_TEST;
      msr_pkg::ST_N2:     if (mul_done) st_d = msr_pkg::ST_LOOP;
      msr_pkg::ST_ROOT:   if (mul_done) st_d = msr_pkg::ST_OUT;
      msr_pkg::ST_OUT:    st_d = msr_pkg::ST_IDLE;
      default:            st_d = msr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    a_d = a_q; h_d = h_q; e_d = e_q; acc_d = acc_q; base_d = base_q;
    a1_d = a1_q; n1_d = n1_q; a2_d = a2_q; n2_d = n2_q; b_d = b_q;
    r0_d = r0_q; r1_d = r1_q; s0_d = s0_q; s1_d = s1_q; q_d = q_q;
    k_d = k_q; i_d = i_q; t_d = t_q; corr_d = corr_q; noinv_d = noinv_q;
    res_d = res_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    mx = acc_q;
    my = base_q;
    case (st_q)
      msr_pkg::ST_IDLE: begin
        noinv_d = 1'b1;
        res_d   = '0;
        corr_d  = 1'b0;
        k_d     = '0;
        i_d     = '0;
        div_start = start && (mod_q >= WIDTH'(2));
      end
      msr_pkg::ST_RED: begin
        if (div_done) begin
          a_d = dr; r0_d = mod_q; r1_d = dr; s0_d = '0; s1_d = WIDTH'(1);
        end
      end
      msr_pkg::ST_INV_DIV: begin
        mx = dq; my = s1_q;
        if (div_done) begin
          q_d = dq; r0_d = r1_q; r1_d = dr;
          mul_start = 1'b1;
        end
      end
      msr_pkg::ST_INV_MUL: begin
        mx = q_q; my = s1_q;
      end
      msr_pkg::ST_INV_UPD: begin
        s0_d = s1_q;
        s1_d = (mp == '0) ? s0_q
             : ((s0_q >= mp) ? s0_q - mp : s0_q + (mod_q - mp));
      end
      msr_pkg::ST_INV_END: begin
        if (r1_q != '0) div_start = 1'b1;
        else if (r0_q == WIDTH'(1)) begin
          a2_d = s0_q; h_d = mod_q - WIDTH'(1);
        end
      end
      msr_pkg::ST_SPLIT: begin
        if (h_q == '0 || h_q[0]) begin
          e_d = (h_q >> 1) + WIDTH'(1); acc_d = WIDTH'(1); base_d = a_q;
        end else begin
          h_d = h_q >> 1; k_d = k_q + 1'b1;
        end
      end
      msr_pkg::ST_PA_TEST, msr_pkg::ST_PN_TEST: begin
        if (e_q != '0) mul_start = 1'b1;
        else if (st_q == msr_pkg::ST_PA_TEST) begin
          a1_d = acc_q; e_d = h_q; acc_d = WIDTH'(1);
          div_start = 1'b1;
        end else begin
          n1_d = acc_q; n2_d = WIDTH'(1);
        end
        if (e_q != '0 && !e_q[0]) begin
          mx = base_q; my = base_q;
        end
      end
      msr_pkg::ST_NR_RED: begin
        if (div_done) base_d = dr;
      end
      msr_pkg::ST_PA_MUL, msr_pkg::ST_PN_MUL: begin
        if (mul_done) begin
          acc_d = mp; mul_start = 1'b1;
        end
        if (mul_done) begin mx = base_q; my = base_q; end
      end
      msr_pkg::ST_PA_SQ, msr_pkg::ST_PN_SQ: begin
        mx = base_q; my = base_q;
        if (mul_done) begin
          base_d = mp; e_d = e_q >> 1;
        end
      end
      msr_pkg::ST_LOOP: begin
        mx = a1_q; my = n2_q;
        mul_start = 1'b1;
      end
      msr_pkg::ST_B: begin
        mx = a2_q; my = mp;
        if (mul_done) begin b_d = mp; mul_start = 1'b1; end
      end
      msr_pkg::ST_C1: begin
        mx = mp; my = b_q;
        if (mul_done) mul_start = 1'b1;
      end
      msr_pkg::ST_C2: begin
        if (mul_done) begin
          base_d = mp; t_d = k_q - 2'd2 - i_q;
        end
      end
      msr_pkg::ST_D_TEST, msr_pkg::ST_E_TEST: begin
        mx = base_q; my = base_q;
        if (t_q != '0) mul_start = 1'b1;
        else if (st_q == msr_pkg::ST_E_TEST) begin
          mx = n2_q; my = base_q; mul_start = 1'b1;
        end
      end
      msr_pkg::ST_D_SQ, msr_pkg::ST_E_SQ: begin
        mx = base_q; my = base_q;
        if (mul_done) begin base_d = mp; t_d = t_q - 1'b1; end
      end
      msr_pkg::ST_CMP: begin
        if (base_q == WIDTH'(1)) corr_d = 1'b0;
        else if (base_q == mod_q - WIDTH'(1)) corr_d = 1'b1;
        if (corr_d) begin
          base_d = n1_q; t_d = i_q;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      msr_pkg::ST_N2: begin
        mx = n2_q; my = base_q;
        if (mul_done) begin n2_d = mp; i_d = i_q + 1'b1; end
      end
      msr_pkg::ST_ROOT: begin
        mx = a1_q; my = n2_q;
        if (mul_done) begin res_d = mp; noinv_d = 1'b0; end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= msr_pkg::ST_IDLE;
      mod_q <= WIDTH'(3);
      nr_q  <= WIDTH'(2);
    end else begin
      st_q <= st_d;
      if (cfg_we_i && cfg_idx_i == 1'(msr_pkg::REG_MODULUS)) mod_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == 1'(msr_pkg::REG_NON_RESIDUE)) nr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; h_q <= h_d; e_q <= e_d; acc_q <= acc_d; base_q <= base_d;
    a1_q <= a1_d; n1_q <= n1_d; a2_q <= a2_d; n2_q <= n2_d; b_q <= b_d;
    r0_q <= r0_d; r1_q <= r1_d; s0_q <= s0_d; s1_q <= s1_d; q_q <= q_d;
    k_q <= k_d; i_q <= i_d; t_q <= t_d; corr_q <= corr_d; noinv_q <= noinv_d;
    res_q <= res_d;
  end

  assign busy         = (st_q != msr_pkg::ST_IDLE);
  assign done_o       = (st_q == msr_pkg::ST_OUT);
  assign no_inverse_o = noinv_q;
  assign root_o       = noinv_q ? '0 : res_q;
  assign other_root_o = (noinv_q || res_q == '0) ? '0 : mod_q - res_q;

  `MSR_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `MSR_ASSERT(a_flag_zero, clk_i, rst_ni, (done_o && no_inverse_o) |-> (root_o == '0))
  `MSR_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, (start && !busy), busy)
endmodule

@@ rtl/core/msr_mulmod.sv @@
`timescale 1ns / 1ps
// Shift-add modular multiply: one multiplier bit per cycle.
module msr_mulmod #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  input  logic [WIDTH-1:0] m_i,
  output logic             done_o,
  output logic [WIDTH-1:0] p_o
);
  msr_pkg::mul_state_e state_q, state_d;
  logic [WIDTH-1:0] acc_q, acc_d, x_q, x_d, y_q, y_d;

  function automatic logic [WIDTH-1:0] addm(input logic [WIDTH-1:0] a,
                                            input logic [WIDTH-1:0] b,
                                            input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] gap;
    gap = m - b;
    if (a >= gap) return a - gap;
    return a + b;
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      msr_pkg::MUL_IDLE: if (start_i) state_d = msr_pkg::MUL_RUN;
      msr_pkg::MUL_RUN:  if (y_q == '0) state_d = msr_pkg::MUL_DONE;
      msr_pkg::MUL_DONE: state_d = start_i ? msr_pkg::MUL_RUN : msr_pkg::MUL_IDLE;
      default:           state_d = msr_pkg::MUL_IDLE;
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    x_d   = x_q;
    y_d   = y_q;
    case (state_q)
      msr_pkg::MUL_IDLE: begin
        acc_d = '0;
        x_d   = x_i;
        y_d   = y_i;
      end
      msr_pkg::MUL_RUN: begin
        if (y_q != '0) begin
          if (y_q[0]) acc_d = addm(acc_q, x_q, m_i);
          x_d = addm(x_q, x_q, m_i);
          y_d = y_q >> 1;
        end
      end
      msr_pkg::MUL_DONE: begin
        // back-to-back start; otherwise the product stays on p_o until the idle state clears it
        if (start_i) begin
          acc_d = '0;
          x_d   = x_i;
          y_d   = y_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msr_pkg::MUL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  assign done_o = (state_q == msr_pkg::MUL_DONE);
  assign p_o    = acc_q;
endmodule

@@ rtl/core/msr_divider.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module msr_divider #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] num_i,
  input  logic [WIDTH-1:0] den_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quo_o,
  output logic [WIDTH-1:0] rem_o
);
  localparam int unsigned CW = $clog2(WIDTH + 1);
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             run_q, run_d, done_q, done_d;
  logic [WIDTH-1:0] quo_q, quo_d, rem_q, rem_d;
  logic [WIDTH:0]   trial;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    trial  = {rem_q, quo_q[WIDTH-1]};
    if (!run_q) begin
      if (start_i) begin
        run_d = 1'b1;
        cnt_d = CW'(WIDTH);
        quo_d = num_i;
        rem_d = '0;
      end
    end else if (cnt_q == '0) begin
      run_d  = 1'b0;
      done_d = 1'b1;
    end else begin
      if (trial >= {1'b0, den_i}) begin
        rem_d = WIDTH'(trial - {1'b0, den_i});
        quo_d = {quo_q[WIDTH-2:0], 1'b1};
      end else begin
        rem_d = trial[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

@@ dv/tb_modular_square_root_unit.sv @@
`timescale 1ns / 1ps
module tb_modular_square_root_unit;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned WDOG_LIMIT = 1000000;
  localparam logic [0:0] IDX_MOD = 1'(msr_pkg::REG_MODULUS);
  localparam logic [0:0] IDX_NR  = 1'(msr_pkg::REG_NON_RESIDUE);

  typedef struct packed {
    logic [WIDTH-1:0] root;
    logic [WIDTH-1:0] other_root;
    logic             no_inverse;
  } sqrt_res_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [0:0]       cfg_idx_i;
  logic [WIDTH-1:0] cfg_data_i;
  logic             start;
  logic [WIDTH-1:0] square_value_i;
  logic             busy;
  logic             done_o;
  logic [WIDTH-1:0] root_o;
  logic [WIDTH-1:0] other_root_o;
  logic             no_inverse_o;

  logic [WIDTH-1:0] mod_q;
  logic [WIDTH-1:0] nr_q;
  sqrt_res_t        root_fifo[$];
  int unsigned      n_errors;
  int unsigned      idle_cycles = 0;

  // prime moduli with a matching non-residue
  logic [WIDTH-1:0] prime_tab[10] = '{32'd5, 32'd7, 32'd13, 32'd17, 32'd97, 32'd41,
                                      32'd65537, 32'd998244353, 32'd2147483647,
                                      32'd4294967291};
  logic [WIDTH-1:0] nres_tab[10]  = '{32'd2, 32'd3, 32'd2, 32'd3, 32'd5, 32'd3,
                                      32'd3, 32'd3, 32'd7, 32'd2};

  modular_square_root_unit #(.WIDTH(WIDTH)) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .square_value_i (square_value_i),
    .busy           (busy),
    .done_o         (done_o),
    .root_o         (root_o),
    .other_root_o   (other_root_o),
    .no_inverse_o   (no_inverse_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic logic [63:0] mulm(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    return ((x % m) * (y % m)) % m;
  endfunction

  function automatic logic [63:0] powm(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = mulm(acc, b, m);
      b = mulm(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [63:0] sqn(logic [63:0] x, int unsigned cnt, logic [63:0] m);
    for (int unsigned t = 0; t < cnt; t++) x = mulm(x, x, m);
    return x;
  endfunction

  function automatic sqrt_res_t tonelli_shanks(logic [WIDTH-1:0] val, logic [WIDTH-1:0] pm,
                                               logic [WIDTH-1:0] nr);
    sqrt_res_t   r;
    logic [63:0] p, a, h, a1, n1, a2, n2, b, c, d, rt;
    logic [63:0] r0, r1, q, tmp;
    longint      s0, s1, stmp;
    int unsigned k;
    bit          corr;
    r = '{root: '0, other_root: '0, no_inverse: 1'b1};
    p = pm;
    if (p < 2) return r;
    a = val % p;
    // extended Euclid, signed coefficients
    r0 = p; r1 = a; s0 = 0; s1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1; r0 = r1; r1 = tmp;
      stmp = s0 - longint'(q) * s1; s0 = s1; s1 = stmp;
    end
    if (r0 != 1) return r;
    s0 = s0 % longint'(p);
    if (s0 < 0) s0 = s0 + longint'(p);
    a2 = s0;
    h = p - 1;
    k = 0;
    while (h != 0 && !h[0]) begin
      h = h >> 1;
      k++;
    end
    a1 = powm(a, (h >> 1) + 1, p);
    n1 = powm(nr, h, p);
    n2 = 64'd1 % p;
    corr = 1'b0;
    for (int unsigned i = 0; i + 2 <= k; i++) begin
      b = mulm(a1, n2, p);
      c = mulm(mulm(a2, b, p), b, p);
      d = sqn(c, k - 2 - i, p);
      if (d == 1) corr = 1'b0;
      else if (d == p - 1) corr = 1'b1;
      if (corr) n2 = mulm(n2, sqn(n1, i, p), p);
    end
    rt = mulm(a1, n2, p);
    r.root = rt[WIDTH-1:0];
    tmp = (p - rt) % p;
    r.other_root = tmp[WIDTH-1:0];
    r.no_inverse = 1'b0;
    return r;
  endfunction

  task automatic report(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    n_errors++;
  endtask

  // accept items, check results, watchdog
  always @(posedge clk_i) begin
    sqrt_res_t exp_r;
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (start && !busy) begin
        root_fifo.push_back(tonelli_shanks(square_value_i, mod_q, nr_q));
      end
      if (done_o) begin
        if (root_fifo.size() == 0) begin
          report("result with no item pending");
        end else begin
          exp_r = root_fifo.pop_front();
          if (root_o !== exp_r.root)
            report($sformatf("root %0h exp %0h", root_o, exp_r.root));
          if (other_root_o !== exp_r.other_root)
            report($sformatf("other_root %0h exp %0h", other_root_o, exp_r.other_root));
          if (no_inverse_o !== exp_r.no_inverse)
            report($sformatf("no_inverse %0b exp %0b", no_inverse_o, exp_r.no_inverse));
        end
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic drain();
    @(posedge clk_i);
    wait (root_fifo.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [WIDTH-1:0] data);
    drain();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == IDX_MOD) mod_q = data;
    else nr_q = data;
  endtask

  task automatic set_field(logic [WIDTH-1:0] p, logic [WIDTH-1:0] n);
    write_reg(IDX_MOD, p);
    write_reg(IDX_NR, n);
  endtask

  task automatic send_item(logic [WIDTH-1:0] val);
    int unsigned gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    repeat (gap) @(posedge clk_i);
    @(posedge clk_i);
    start          <= 1'b1;
    square_value_i <= val;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    start <= 1'b0;
  endtask

  task automatic test_reset_field();
    send_item(32'd0);
    send_item(32'd1);
    send_item(32'd2);
    send_item(32'hFFFF_FFFF);
  endtask

  task automatic test_degenerate_modulus();
    set_field(32'd0, 32'd2);
    send_item(32'd5);
    write_reg(IDX_MOD, 32'd1);
    send_item(32'hFFFF_FFFF);
    write_reg(IDX_MOD, 32'd2);
    send_item(32'd1);
  endtask

  task automatic test_small_prime();
    set_field(32'd17, 32'd3);
    send_item(32'd0);
    send_item(32'd16);
    send_item(32'd13);
    send_item(32'd2);
    send_item(32'd3);
    send_item(32'd34);
  endtask

  task automatic test_wide_modulus();
    set_field(32'd4294967291, 32'd2);
    send_item(32'd4);
    send_item(32'hFFFF_FFFF);
    set_field(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'h1234_5678);
    send_item(32'h8000_0000);
  endtask

  task automatic test_random();
    int unsigned sel, cnt;
    logic [WIDTH-1:0] p, n, x, v;
    for (int ph = 0; ph < 9; ph++) begin
      sel = (ph < 6) ? $urandom_range(0, 5) : $urandom_range(6, 9);
      p = prime_tab[sel];
      n = nres_tab[sel];
      if ($urandom_range(0, 3) == 0) n = (ph[0]) ? 32'd1 : $urandom;
      set_field(p, n);
      cnt = (ph < 6) ? 14 : 4;
      for (int j = 0; j < cnt; j++) begin
        x = $urandom;
        case ($urandom_range(0, 7))
          0, 1:    v = $urandom;
          2:       v = p * $urandom_range(0, 3);
          default: v = mulm(x, x, p);
        endcase
        send_item(v);
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    start          = 1'b0;
    square_value_i = '0;
    mod_q          = 32'd3;
    nr_q           = 32'd2;
    n_errors       = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_field();
    test_degenerate_modulus();
    test_small_prime();
    test_wide_modulus();
    test_random();

    drain();
    repeat (50) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/msr_pkg.sv
rtl/core/msr_mulmod.sv
rtl/core/msr_divider.sv
rtl/core/modular_square_root_unit.sv
dv/tb_modular_square_root_unit.sv
